>>> rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and round functions for the byte-stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned QueueDepth = 4;

  // Classified command passed from the front end to the compression engine.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } cmd_t;

  // Compression engine sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } eng_state_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t initial_h(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher channels
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sha256_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts transactions, drops empty ones and queues commands for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_front (
  input  wire logic               clk,
  input  wire logic               rst,
  sha256_in_if.sink               in_ch,
  output sha256_pkg::cmd_t        cmd,
  output logic                    cmd_valid,
  input  wire logic               cmd_pop
);
  localparam int unsigned Depth = sha256_pkg::QueueDepth;
  localparam int unsigned Aw = $clog2(Depth);

  sha256_pkg::cmd_t  mem [Depth];
  logic [Aw-1:0]     wr_ptr;
  logic [Aw-1:0]     rd_ptr;
  logic [Aw:0]       count;
  logic              push;
  logic              pop;

  assign in_ch.ready = (count != (Aw+1)'(Depth));
  // Items with neither flag set do nothing, so they are not queued.
  assign push = in_ch.valid && in_ch.ready && (in_ch.byte_present || in_ch.end_of_message);
  assign pop = cmd_pop && cmd_valid;
  assign cmd_valid = (count != '0);
  assign cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data_byte: in_ch.data_byte, byte_present: in_ch.byte_present,
                       end_of_message: in_ch.end_of_message};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/sha256_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Buffers bytes, pads, runs 64 rounds per block and emits the digest.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_engine (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire sha256_pkg::cmd_t cmd,
  input  wire logic         cmd_valid,
  output logic              cmd_pop,
  sha256_out_if.source      out_ch
);
  typedef sha256_pkg::word_t word_t;

  sha256_pkg::eng_state_t state, state_next;

  word_t        h [8];
  word_t        v [8];
  word_t        w [16];          // message schedule window, w[0] is current
  logic [63:0]  byte_count;
  logic [5:0]   pos;             // byte position within current block
  logic [5:0]   rnd;
  logic [2:0]   add_idx;
  logic         finishing;       // message closed, padding in progress
  logic         len_done;        // length field written into final block
  logic         pad_marker_done;
  logic [63:0]  bit_len;
  logic [2:0]   emit_idx;

  word_t        t1, t2, w_new;
  logic [7:0]   pad_byte;
  logic         pad_write;

  always_comb begin
    t1 = v[7] + sha256_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
       + sha256_pkg::round_k(rnd) + w[0];
    t2 = sha256_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = sha256_pkg::sig1(w[14]) + w[9] + sha256_pkg::sig0(w[1]) + w[0];
  end

  // Padding byte: marker, zeros, then the length big-endian from position 56.
  always_comb begin
    pad_write = 1'b0;
    pad_byte = 8'h00;
    if (!pad_marker_done) begin
      pad_byte = 8'h80;
    end else if (len_done && pos >= 6'd56) begin
      pad_byte = bit_len[8'(63 - 8 * (int'(pos) - 56)) -: 8];
    end
    pad_write = 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.byte_present && pos == 6'd63) state_next = sha256_pkg::ST_ROUND;
          else if (cmd.end_of_message) state_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_PAD: begin
        if (pos == 6'd63) state_next = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        if (rnd == 6'd63) state_next = sha256_pkg::ST_ADD;
      end
      sha256_pkg::ST_ADD: begin
        if (add_idx == 3'd7) begin
          if (!finishing) state_next = sha256_pkg::ST_IDLE;
          else if (len_done) state_next = sha256_pkg::ST_EMIT;
          else state_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (out_ch.ready && emit_idx == 3'd7) state_next = sha256_pkg::ST_IDLE;
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        // An item with a byte that fills the block and also ends the message
        // stays queued; its end flag is handled after the block compresses.
        cmd_pop = cmd_valid && !(cmd.byte_present && pos == 6'd63 && cmd.end_of_message);
      end
      sha256_pkg::ST_EMIT: out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  assign out_ch.digest_word = h[emit_idx];
  assign out_ch.word_index = emit_idx;
  assign out_ch.last_word = (emit_idx == 3'd7);

  logic end_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
      byte_count <= '0;
      pos <= '0;
      rnd <= '0;
      add_idx <= '0;
      finishing <= 1'b0;
      len_done <= 1'b0;
      pad_marker_done <= 1'b0;
      emit_idx <= '0;
      end_pending <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::initial_h(3'(i));
    end else begin
      state <= state_next;
      unique case (state)
        sha256_pkg::ST_IDLE: begin
          if (cmd_valid && !end_pending) begin
            if (cmd.byte_present) begin
              w[pos[5:2]][8'(31 - 8 * int'(pos[1:0])) -: 8] <= cmd.data_byte;
              byte_count <= byte_count + 64'd1;
              pos <= pos + 6'd1;
              if (pos == 6'd63) begin
                for (int i = 0; i < 8; i++) v[i] <= h[i];
                rnd <= '0;
                end_pending <= cmd.end_of_message;
              end else if (cmd.end_of_message) begin
                finishing <= 1'b1;
                pad_marker_done <= 1'b0;
                len_done <= 1'b0;
                bit_len <= {byte_count[60:0] + 61'd1, 3'b000};
              end
            end else begin
              finishing <= 1'b1;
              pad_marker_done <= 1'b0;
              len_done <= 1'b0;
              bit_len <= {byte_count[60:0], 3'b000};
            end
          end else if (cmd_valid && end_pending) begin
            // Deferred end of a message whose last byte completed a block.
            end_pending <= 1'b0;
            finishing <= 1'b1;
            pad_marker_done <= 1'b0;
            len_done <= 1'b0;
            bit_len <= {byte_count[60:0], 3'b000};
          end
        end
        sha256_pkg::ST_PAD: begin
          if (pad_write) begin
            w[pos[5:2]][8'(31 - 8 * int'(pos[1:0])) -: 8] <= pad_byte;
          end
          pad_marker_done <= 1'b1;
          pos <= pos + 6'd1;
          if (pos == 6'd55 && (pad_marker_done || pos != 6'd63)) len_done <= 1'b1;
          if (pos == 6'd63) begin
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            rnd <= '0;
          end
        end
        sha256_pkg::ST_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          rnd <= rnd + 6'd1;
          add_idx <= '0;
        end
        sha256_pkg::ST_ADD: begin
          h[add_idx] <= h[add_idx] + v[add_idx];
          add_idx <= add_idx + 3'd1;
          emit_idx <= '0;
        end
        sha256_pkg::ST_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::initial_h(3'(i));
              byte_count <= '0;
              pos <= '0;
              finishing <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hasher
// Top level: front-end queue feeding the compression engine.
// ----------------------------------------------------------------------------
// The hasher takes one message byte per input transaction and returns the
// SHA-256 digest as eight 32-bit output transactions, most significant word
// first, after a transaction with end_of_message set. The single shared
// round unit runs the 64 rounds of each full 64-byte block and then folds
// the result into the chaining words. Closing a message adds padding and
// one or two block compressions before the digest appears. A four-entry
// queue in front of the engine lets the source keep sending while a block
// compresses.
`default_nettype none
module sha256_byte_stream_hasher (
  input wire logic     clk,
  input wire logic     rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  sha256_pkg::cmd_t cmd;
  logic             cmd_valid;
  logic             cmd_pop;

  // Front end: accepts and filters transactions.
  sha256_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // Back end: buffering, padding, compression and digest output.
  sha256_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

>>> dv/sha256_tb_if.sv
// ----------------------------------------------------------------------------
// Testbench channel note
// The hasher's own channel interfaces are reused; this file holds the
// testbench's record type for one digest word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
package sha256_tb_pkg;
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_rec_t;
endpackage

>>> dv/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels, hashes the accepted bytes itself and compares every
// digest word with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module sha256_digest_checker (
  input wire logic clk,
  input wire logic rst,
  sha256_in_if     in_mon,
  sha256_out_if    out_mon,
  output int       fail_count,
  output int       pending_words,
  output int       digests_seen
);
  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [63:0] msg_len;
  sha256_tb_pkg::digest_rec_t expected_words [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic absorb(input logic [7:0] b, input logic has_byte, input logic close);
    int pos;
    logic [63:0] bits;
    sha256_tb_pkg::digest_rec_t rec;
    if (has_byte) begin
      msg_block[msg_len[5:0]] = b;
      msg_len++;
      if (msg_len[5:0] == 6'd0) compress();
    end
    if (close) begin
      pos = int'(msg_len[5:0]);
      bits = msg_len << 3;
      msg_block[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          msg_block[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        rec = '{hash_state[i], 3'(i), i == 7};
        expected_words = {expected_words, rec};
      end
      hash_state = H_INIT;
      msg_len = '0;
    end
  endtask

  always @(posedge clk) begin
    sha256_tb_pkg::digest_rec_t got, want;
    if (rst) begin
      hash_state = H_INIT;
      msg_len = '0;
      expected_words.delete();
      fail_count <= 0;
      digests_seen <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        absorb(in_mon.data_byte, in_mon.byte_present, in_mon.end_of_message);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.digest_word, out_mon.word_index, out_mon.last_word};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected digest word %h", $time, got.digest_word);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got != want) begin
            $display("%0t: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                     want.digest_word, want.word_index, want.last_word,
                     got.digest_word, got.word_index, got.last_word);
            fail_count <= fail_count + 1;
          end
          if (want.last_word) digests_seen <= digests_seen + 1;
        end
      end
    end
    pending_words <= expected_words.size();
  end
endmodule

>>> dv/sha256_byte_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hasher testbench
// Sends messages of many lengths with random flow control and lets the
// checker hash them alongside; reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module sha256_byte_stream_hasher_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   fail_count, pending_words, digests_seen;
  int   sent_items = 0;
  bit   stall_long = 1'b0;  // set by the sender to ask for a long receiver hold-off
  bit   long_done;          // set by the receiver once that hold-off is over
  int   hold_cycles;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_byte_stream_hasher dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  sha256_digest_checker checker_i (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_words(pending_words), .digests_seen(digests_seen));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sends one transaction after a random gap and waits for its acceptance. The
  // gap is sometimes skipped entirely so that back-to-back bursts also occur.
  // Valid stays high after acceptance; the next gap or drain() lowers it.
  task automatic send_item(input logic [7:0] b, input logic has_byte, input logic close,
                           input bit no_gap);
    int gap;
    gap = no_gap ? 0 : int'($urandom_range(0, 11));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.byte_present <= has_byte;
    in_ch.end_of_message <= close;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  // Sends a whole message of the given length, closing it on its last byte
  // or, at random, with a separate end transaction carrying no byte. Idle
  // transactions with neither flag set are scattered in as noise.
  task automatic send_message(input int len, input bit burst);
    bit separate_end;
    separate_end = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0, burst);
      send_item(8'($urandom), 1'b1, !separate_end && i == len - 1, burst);
    end
    if (separate_end) send_item(8'($urandom), 1'b0, 1'b1, burst);
  endtask

  // Pauses the sender until the checker has seen every predicted word.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // Receiver: random stalls per transaction, with one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= 0;
      long_done <= 1'b0;
    end else if (stall_long && !long_done) begin
      out_ch.ready <= 1'b0;
      if (hold_cycles >= 400) begin
        long_done <= 1'b1;
        hold_cycles <= 0;
      end else begin
        hold_cycles <= hold_cycles + 1;
      end
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (out_ch.valid && out_ch.ready) begin
      // Draw the wait before the next transaction; a third of the time none.
      if ($urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        hold_cycles <= $urandom_range(0, 11);
        out_ch.ready <= 1'b0;
      end
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before the first edge.
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.end_of_message = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the empty message (a lone end with no byte), pure noise,
    // single bytes at both extremes with the end on the byte, and the
    // three-byte message abc.
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1, 1'b0);
    send_item(8'h61, 1'b1, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1, 1'b0);
    drain();

    // Long receiver hold-off while the sender keeps offering short messages,
    // so the front queue fills and the input stalls.
    stall_long <= 1'b1;
    send_message(55, 1'b1);
    send_message(3, 1'b1);
    drain();

    // Random part: mostly short messages, a few across block boundaries.
    while (sent_items < 350) begin
      case ($urandom_range(0, 5))
        0:       send_message($urandom_range(56, 130), $urandom_range(0, 3) == 0);
        1:       send_message(0, 1'b0);
        default: send_message($urandom_range(1, 12), $urandom_range(0, 3) == 0);
      endcase
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (300) @(posedge clk);
    $display("Sent %0d transactions; %0d digests checked, message lengths 0 to 130 bytes.",
             sent_items, digests_seen);
    if (fail_count == 0 && pending_words == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/sha256_pkg.sv
rtl/core/sha256_if.sv
rtl/core/sha256_front.sv
rtl/core/sha256_engine.sv
rtl/core/sha256_byte_stream_hasher.sv
dv/sha256_tb_if.sv
dv/sha256_digest_checker.sv
dv/sha256_byte_stream_hasher_tb.sv
